>>> design/lpi_pkg.sv
package lpi_pkg;

  // Scale of one percent step and the width of a percent digit group.
  localparam int unsigned QW          = 7;
  localparam logic [QW-1:0] PCT_SCALE = 7'd100;
  localparam logic [QW-1:0] PCT_HUND_MAX = 7'd99;

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_DIV1,
    ST_MUL2,
    ST_DIV2,
    ST_DONE
  } lpi_state_t;

endpackage

>>> design/lpi_mul.sv
// Bit-serial multiplier by the constant percent scale, MSB of the constant first.
module lpi_mul import lpi_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [W-1:0]    op,
  output logic            done,
  output logic [W+QW-1:0] prod
);

  localparam int unsigned CW = $clog2(QW);

  logic [W-1:0]    op_r, op_nxt;
  logic [W+QW-1:0] acc_r, acc_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            run_r, run_nxt;
  logic            done_r, done_nxt;

  always_comb begin
    op_nxt   = op_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      op_nxt  = op;
      acc_nxt = '0;
      cnt_nxt = CW'(QW - 1);
      run_nxt = 1'b1;
    end else if (run_r) begin
      acc_nxt = {acc_r[W+QW-2:0], 1'b0}
              + (PCT_SCALE[cnt_r] ? {{QW{1'b0}}, op_r} : '0);
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    op_r  <= op_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

>>> design/lpi_div.sv
// Restoring divider that yields one quotient bit per cycle. The quotient is
// known to fit in QW bits, so the divisor starts shifted up by QW-1 places.
module lpi_div import lpi_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [W+QW-1:0] num,
  input  logic [W-1:0]    den,
  output logic            done,
  output logic [QW-1:0]   quo,
  output logic [W-1:0]    rem
);

  localparam int unsigned CW = $clog2(QW);

  logic [W+QW-1:0] r_r, r_nxt;
  logic [W+QW-1:0] d_r, d_nxt;
  logic [QW-1:0]   q_r, q_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            run_r, run_nxt;
  logic            done_r, done_nxt;
  logic [W+QW:0]   diff;
  logic            ge;

  assign diff = {1'b0, r_r} - {1'b0, d_r};
  assign ge   = ~diff[W+QW];

  always_comb begin
    r_nxt    = r_r;
    d_nxt    = d_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      r_nxt   = num;
      d_nxt   = {1'b0, den, {(QW-1){1'b0}}};
      q_nxt   = '0;
      cnt_nxt = CW'(QW - 1);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (ge) begin
        r_nxt = diff[W+QW-1:0];
      end
      q_nxt = {q_r[QW-2:0], ge};
      d_nxt = {1'b0, d_r[W+QW-1:1]};
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    r_r <= r_nxt;
    d_r <= d_nxt;
    q_r <= q_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = r_r[W-1:0];

endmodule

>>> design/load_percent_from_idle_count.sv
// Processor load estimate from idle-loop counts.
//
// Input channel (in_*): one item per measurement window, carrying the idle
// loop count of that window in in_tdata. Only the low COUNT_WIDTH bits count.
// Result channel (out_*): exactly one item per input item, carrying the busy
// share as whole percent and hundredths of a percent, both truncated.
// The block keeps the largest count seen so far as its reference. A count at
// or above the reference replaces it and reports 0.00; the first window after
// reset calibrates the reference this way.
// A count that is not below the reference goes to the done state and from
// there into the output register. Otherwise the bit-serial datapath runs two
// passes of a times-100 multiply and a 7-step divide (multiply, divide,
// multiply, divide) before the done state. One item is processed at a time;
// the next is accepted once the result has moved into the output register.
// Reset (rst_n low, synchronous) clears the reference and empties the output.
// When the receiver stalls, the result holds in the output register while a
// new item is still accepted and processed; it then waits for the register.
module load_percent_from_idle_count import lpi_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] idle_count
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [6:0] usage_whole, [13:7] usage_hundredths
);

  localparam int unsigned W = COUNT_WIDTH;

  lpi_state_t state_r, state_nxt;

  logic [W-1:0]    ref_r, ref_nxt;
  logic [QW-1:0]   whole_r, whole_nxt;
  logic [QW-1:0]   hund_r, hund_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [QW-1:0]   out_whole_r, out_whole_nxt;
  logic [QW-1:0]   out_hund_r, out_hund_nxt;

  // The input field is zero-extended or truncated to the count width.
  logic [IN_TDATA_W+W-1:0] in_ext;
  logic [W-1:0]            count;

  logic            mul_start, mul_done;
  logic [W-1:0]    mul_op;
  logic [W+QW-1:0] mul_prod;
  logic            div_start, div_done;
  logic [QW-1:0]   div_quo;
  logic [W-1:0]    div_rem;

  assign in_ext  = {{W{1'b0}}, in_tdata};
  assign count   = in_ext[W-1:0];

  lpi_mul #(.W(W)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op    (mul_op),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  lpi_div #(.W(W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mul_prod),
    .den   (ref_r),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_comb begin
    state_nxt     = state_r;
    ref_nxt       = ref_r;
    whole_nxt     = whole_r;
    hund_nxt      = hund_r;
    out_valid_nxt = out_valid_r;
    out_whole_nxt = out_whole_r;
    out_hund_nxt  = out_hund_r;
    mul_start     = 1'b0;
    mul_op        = div_rem;
    div_start     = 1'b0;
    in_tready     = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (count < ref_r) begin
            // Busy share is reference minus count; scale it by 100 first.
            mul_op    = ref_r - count;
            mul_start = 1'b1;
            state_nxt = ST_MUL1;
          end else begin
            ref_nxt   = count;
            whole_nxt = '0;
            hund_nxt  = '0;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_MUL1: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_nxt = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (div_done) begin
          // Whole percent is the quotient; the remainder is scaled again.
          whole_nxt = div_quo;
          mul_start = 1'b1;
          state_nxt = ST_MUL2;
        end
      end
      ST_MUL2: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_nxt = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (div_done) begin
          hund_nxt  = div_quo;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Move the result into the output register once it is free.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_whole_nxt = whole_r;
          out_hund_nxt  = hund_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ref_r       <= '0;
      whole_r     <= '0;
      hund_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ref_r       <= ref_nxt;
      whole_r     <= whole_nxt;
      hund_r      <= hund_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_whole_r <= out_whole_nxt;
    out_hund_r  <= out_hund_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-2*QW){1'b0}}, out_hund_r, out_whole_r};

endmodule

>>> design/lpi_checker.sv
module lpi_checker import lpi_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [QW-1:0] whole;
  logic [QW-1:0] hund;

  assign whole = out_tdata[QW-1:0];
  assign hund  = out_tdata[2*QW-1:QW];

  // A result waiting on the receiver stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  a_whole_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> whole <= PCT_SCALE)
    else $error("whole percent above 100");

  a_hund_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> hund <= PCT_HUND_MAX)
    else $error("hundredths above 99");

  // Full load can only come from a zero count, which leaves no fraction.
  a_full_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && whole == PCT_SCALE |-> hund == '0)
    else $error("fraction reported at full load");

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in work");

endmodule

bind load_percent_from_idle_count lpi_checker u_lpi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
